@@ rtl/point_in_polygon_ray_cast_macros.svh @@
// Assertion macros shared by the polygon block.
`ifndef POINT_IN_POLYGON_RAY_CAST_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PIP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Implication whose consequence is checked in the following cycle.
`define PIP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

@@ rtl/pip_pkg.sv @@
// Shared types and constants for the polygon block.
`timescale 1ns / 1ps
package pip_pkg;
   localparam int MaxVertices = 64;
   localparam int AddrW = $clog2(MaxVertices);
   localparam int CountW = $clog2(MaxVertices + 1);
   localparam int CoordW = 16;
   localparam int AreaW = 33;
   localparam int MinPolyVerts = 3;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_POINT  = 2'd2,
      ACT_AREA   = 2'd3
   } action_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic            load;        // capture the input beat
      logic            clear;       // empty the polygon
      logic            append;      // write the vertex
      logic            rd_start;    // read vertex 0 and set the walk index
      logic            rd_next;     // read the next vertex of the walk
      logic            edge_en;     // evaluate the edge held in a and b
      logic            close_edge;  // load the closing edge, last vertex to vertex 0
   } cmd_type;

   // Datapath status back to the controller.
   typedef struct packed {
      action_type act;
      logic       last_read;
      logic       last_edge;
      logic       short_poly;
   } stat_type;
endpackage

@@ rtl/pip_ram.sv @@
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module pip_ram #(
   parameter int Width = 16,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/pip_datapath.sv @@
// Vertex store, edge walk and the crossing and area arithmetic.
`timescale 1ns / 1ps
module pip_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pip_pkg::cmd_type                  cmd,
   output pip_pkg::stat_type                 stat,
   input  logic [1:0]                        in_action,
   input  logic signed [pip_pkg::CoordW-1:0] in_x,
   input  logic signed [pip_pkg::CoordW-1:0] in_y,
   output logic                              res_inside,
   output logic [pip_pkg::AreaW-1:0]         res_area,
   output logic [pip_pkg::CountW-1:0]        res_count,
   output logic                              res_dropped
);
   localparam int W = pip_pkg::CoordW;
   localparam int AW = pip_pkg::AddrW;
   localparam int CW = pip_pkg::CountW;
   // Edge terms need 2W+1 bits; the address bits cover the sum over every stored edge.
   localparam int SumW = 2 * W + 2 + AW;

   logic [1:0]           act_ff;
   logic signed [W-1:0]  px_ff, py_ff;
   logic [CW-1:0]        count_ff;
   logic                 drop_ff;
   logic [AW-1:0]        idx_ff, idx_in;
   logic signed [W-1:0]  ax_ff, ay_ff, bx_ff, by_ff, fx_ff, fy_ff;
   logic                 first_ff;
   logic                 rdv_ff;
   logic                 hits_ff, stop_ff, onres_ff;
   logic signed [SumW-1:0] sum_ff;
   logic [W-1:0]         rx, ry;
   logic                 wr_en;

   // Vertex stores.
   assign wr_en = cmd.append && (count_ff < CW'(pip_pkg::MaxVertices));
   pip_ram #(.Width(W), .Depth(pip_pkg::MaxVertices)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(px_ff), .rd_addr(idx_in), .rd_data(rx));
   pip_ram #(.Width(W), .Depth(pip_pkg::MaxVertices)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[AW-1:0]),
      .wr_data(py_ff), .rd_addr(idx_in), .rd_data(ry));

   // Walk index: the address the RAM reads at this edge.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.rd_next) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   // Edge arithmetic on 19-bit signed operands with 39-bit orientation values.
   logic signed [W+2:0] qx, qy, rxe;
   logic signed [2*W+6:0] o1v, o2v, o3v, o4v, o5v;
   logic signed [2*W+1:0] cross_t;
   logic [1:0] o1, o2, o3, o4, o5;
   logic w1, w2, w5, hit;

   function automatic logic [1:0] sgn(input logic signed [2*W+6:0] v);
      if (v == '0) return 2'd0;
      return (v > 0) ? 2'd1 : 2'd2;
   endfunction

   function automatic logic signed [2*W+6:0] orv(
      input logic signed [W+2:0] ax_, ay_, bx_, by_, cx_, cy_);
      return (by_ - ay_) * (cx_ - bx_) - (bx_ - ax_) * (cy_ - by_);
   endfunction

   function automatic logic wi(input logic signed [W+2:0] ax_, ay_, bx_, by_,
                               cx_, cy_);
      logic signed [W+2:0] xa, xi, ya, yi;
      xa = (ax_ > cx_) ? ax_ : cx_;
      xi = (ax_ < cx_) ? ax_ : cx_;
      ya = (ay_ > cy_) ? ay_ : cy_;
      yi = (ay_ < cy_) ? ay_ : cy_;
      return bx_ <= xa && bx_ >= xi && by_ <= ya && by_ >= yi;
   endfunction

   always_comb begin
      qx = (W+3)'(px_ff);
      qy = (W+3)'(py_ff);
      rxe = (W+3)'(65536);
      o1v = orv((W+3)'(ax_ff), (W+3)'(ay_ff), (W+3)'(bx_ff), (W+3)'(by_ff), qx, qy);
      o2v = orv((W+3)'(ax_ff), (W+3)'(ay_ff), (W+3)'(bx_ff), (W+3)'(by_ff), rxe, qy);
      o3v = orv(qx, qy, rxe, qy, (W+3)'(ax_ff), (W+3)'(ay_ff));
      o4v = orv(qx, qy, rxe, qy, (W+3)'(bx_ff), (W+3)'(by_ff));
      o5v = orv((W+3)'(ax_ff), (W+3)'(ay_ff), qx, qy, (W+3)'(bx_ff), (W+3)'(by_ff));
      o1 = sgn(o1v);
      o2 = sgn(o2v);
      o3 = sgn(o3v);
      o4 = sgn(o4v);
      o5 = sgn(o5v);
      w1 = wi((W+3)'(ax_ff), (W+3)'(ay_ff), qx, qy, (W+3)'(bx_ff), (W+3)'(by_ff));
      w2 = wi((W+3)'(ax_ff), (W+3)'(ay_ff), rxe, qy, (W+3)'(bx_ff), (W+3)'(by_ff));
      w5 = wi((W+3)'(ax_ff), (W+3)'(ay_ff), qx, qy, (W+3)'(bx_ff), (W+3)'(by_ff));
      hit = (o1 != o2 && o3 != o4) || (o1 == 2'd0 && w1) || (o2 == 2'd0 && w2)
         || (o3 == 2'd0 && wi(qx, qy, (W+3)'(ax_ff), (W+3)'(ay_ff), rxe, qy))
         || (o4 == 2'd0 && wi(qx, qy, (W+3)'(bx_ff), (W+3)'(by_ff), rxe, qy));
      cross_t = (2*W+2)'(ax_ff * by_ff) - (2*W+2)'(ay_ff * bx_ff);
   end

   // Registers of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CW'(1);
      end
      idx_ff <= idx_in;
      rdv_ff <= cmd.rd_start || cmd.rd_next;
      if (cmd.load) begin
         act_ff <= in_action;
         px_ff <= in_x;
         py_ff <= in_y;
         drop_ff <= 1'b0;
         sum_ff <= '0;
         hits_ff <= 1'b0;
         stop_ff <= 1'b0;
         onres_ff <= 1'b0;
         first_ff <= 1'b1;
      end
      if (cmd.append) begin
         drop_ff <= !wr_en;
      end
      // Shift the fresh vertex into the edge pair; keep vertex 0 for closing.
      if (rdv_ff) begin
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
         bx_ff <= signed'(rx);
         by_ff <= signed'(ry);
         if (first_ff) begin
            fx_ff <= signed'(rx);
            fy_ff <= signed'(ry);
            first_ff <= 1'b0;
         end
      end else if (cmd.close_edge) begin
         // Closing edge: the last vertex moves to a and vertex 0 becomes b.
         ax_ff <= bx_ff;
         ay_ff <= by_ff;
         bx_ff <= fx_ff;
         by_ff <= fy_ff;
      end
      if (cmd.edge_en) begin
         sum_ff <= sum_ff + SumW'(cross_t);
      end
      // Crossing count; a point on a crossed edge ends the count.
      if (cmd.edge_en && !stop_ff && act_ff == pip_pkg::ACT_POINT) begin
         if (hit) begin
            if (o5 == 2'd0) begin
               stop_ff <= 1'b1;
               onres_ff <= w5;
            end else begin
               hits_ff <= !hits_ff;
            end
         end
      end
      if (cmd.rd_start) begin
         first_ff <= 1'b1;
      end
   end

   logic signed [SumW-1:0] abs_sum;
   always_comb begin
      abs_sum = (sum_ff < 0) ? -sum_ff : sum_ff;
      stat.act = pip_pkg::action_type'(act_ff);
      stat.last_read = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.last_edge = ((CW'(idx_ff) + CW'(1)) == count_ff) && !rdv_ff;
      stat.short_poly = (count_ff < CW'(pip_pkg::MinPolyVerts));
      res_count = count_ff;
      res_dropped = (act_ff == pip_pkg::ACT_APPEND) && drop_ff;
      res_inside = 1'b0;
      res_area = '0;
      if (act_ff == pip_pkg::ACT_POINT && !stat.short_poly) begin
         res_inside = stop_ff ? onres_ff : hits_ff;
      end
      if (act_ff == pip_pkg::ACT_AREA) begin
         res_area = (abs_sum > SumW'(64'h1_FFFF_FFFF)) ? '1 : abs_sum[pip_pkg::AreaW-1:0];
      end
   end
endmodule

@@ rtl/pip_ctrl.sv @@
// Sequencer for one beat: load, walk the edges for queries, emit the result.
`timescale 1ns / 1ps
module pip_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   input  pip_pkg::stat_type stat,
   output pip_pkg::cmd_type  cmd
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DEC   = 6'b000010,
      ST_FILL  = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_CLOSE = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      wait_in = wait_ff;
      cmd = '0;
      in_ready = (state_ff == ST_IDLE);
      out_valid = (state_ff == ST_OUT);
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            unique case (stat.act)
               pip_pkg::ACT_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in = ST_OUT;
               end
               pip_pkg::ACT_APPEND: begin
                  cmd.append = 1'b1;
                  state_in = ST_OUT;
               end
               default: begin
                  // Fewer than three vertices answer zero for both queries.
                  if (stat.short_poly) begin
                     state_in = ST_OUT;
                  end else begin
                     cmd.rd_start = 1'b1;
                     wait_in = 2'd1;
                     state_in = ST_FILL;
                  end
               end
            endcase
         end
         // Two more reads fill the edge pair before the first edge is evaluated.
         ST_FILL: begin
            cmd.rd_next = 1'b1;
            if (wait_ff == 2'd0) begin
               state_in = ST_WALK;
            end else begin
               wait_in = wait_ff - 2'd1;
            end
         end
         // One stored edge per cycle; the last one also loads the closing edge.
         ST_WALK: begin
            cmd.edge_en = 1'b1;
            if (stat.last_edge) begin
               cmd.close_edge = 1'b1;
               state_in = ST_CLOSE;
            end else if (!stat.last_read) begin
               cmd.rd_next = 1'b1;
            end
         end
         ST_CLOSE: begin
            cmd.edge_en = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff <= wait_in;
      end
   end
endmodule

@@ rtl/point_in_polygon_ray_cast.sv @@
// Top level of the polygon store with point and area queries.
`timescale 1ns / 1ps
// Holds a polygon of up to 64 vertices in two RAMs, each with one write port
// and one registered read port. Clear and append beats pass from the idle
// state through the decode state to the output state, as do queries on fewer
// than three vertices. Other point and area queries walk each stored edge once
// through the RAM read port. One beat is in work at a time and a waiting result
// holds off the next input beat.
`include "point_in_polygon_ray_cast_macros.svh"
module point_in_polygon_ray_cast (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // action
   input  logic [31:0] req_tdata,   // x_coord [15:0], y_coord [31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // inside_res [0], twice_area [33:1],
                                    // vertex_count [40:34], dropped [41], zero fill
);
   pip_pkg::cmd_type  cmd;
   pip_pkg::stat_type stat;
   logic                                pt_inside;
   logic [pip_pkg::AreaW-1:0]           area;
   logic [pip_pkg::CountW-1:0]          count;
   logic                                dropped;

   pip_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .stat(stat), .cmd(cmd));

   pip_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_action(req_tuser), .in_x(signed'(req_tdata[15:0])),
      .in_y(signed'(req_tdata[31:16])), .res_inside(pt_inside), .res_area(area),
      .res_count(count), .res_dropped(dropped));

   assign rsp_tdata = {6'd0, dropped, count, area, pt_inside};

   // No input is taken while a result beat waits.
   `PIP_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "input taken during output")
   // The held count never exceeds the store depth.
   `PIP_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count <= 7'd64, "count overflow")
   // A drop is only reported with a full store.
   `PIP_ASSERT_IMP(a_drop_full, clock, reset, rsp_tvalid && dropped, count == 7'd64, "drop not full")
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the polygon store with point and area queries.
`timescale 1ns / 1ps
module tb_top;
   localparam longint AreaCap = 64'd8589934591;
   localparam longint RayEndX = 65536;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic        in_poly;
      logic [32:0] area;
      logic [6:0]  count;
      logic        drop;
   } poly_result;

   typedef struct {
      pip_pkg::action_type act;
      int                  x;
      int                  y;
      bit                  typed;
      poly_result          res;
   } stim_row;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = pip_pkg::ACT_CLEAR;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   // Shadow copy of the polygon held by the block.
   int          shadow_x[pip_pkg::MaxVertices];
   int          shadow_y[pip_pkg::MaxVertices];
   int          shadow_count = 0;
   poly_result  pending_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          sent_count = 0;

   point_in_polygon_ray_cast dut (.*);

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // 0 collinear, 1 clockwise, 2 counterclockwise.
   function automatic int turn_of(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
      longint v;
      v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
      if (v == 0) return 0;
      return (v > 0) ? 1 : 2;
   endfunction

   // True when b lies in the bounding box of a and c.
   function automatic bit in_box(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
      longint xmax, xmin, ymax, ymin;
      xmax = ax > cx ? ax : cx;
      xmin = ax < cx ? ax : cx;
      ymax = ay > cy ? ay : cy;
      ymin = ay < cy ? ay : cy;
      return bx <= xmax && bx >= xmin && by <= ymax && by >= ymin;
   endfunction

   function automatic bit segs_meet(longint ax, longint ay, longint bx, longint by,
                                    longint cx, longint cy, longint dx, longint dy);
      int o1, o2, o3, o4;
      o1 = turn_of(ax, ay, bx, by, cx, cy);
      o2 = turn_of(ax, ay, bx, by, dx, dy);
      o3 = turn_of(cx, cy, dx, dy, ax, ay);
      o4 = turn_of(cx, cy, dx, dy, bx, by);
      if (o1 != o2 && o3 != o4) return 1;
      if (o1 == 0 && in_box(ax, ay, cx, cy, bx, by)) return 1;
      if (o2 == 0 && in_box(ax, ay, dx, dy, bx, by)) return 1;
      if (o3 == 0 && in_box(cx, cy, ax, ay, dx, dy)) return 1;
      if (o4 == 0 && in_box(cx, cy, bx, by, dx, dy)) return 1;
      return 0;
   endfunction

   // Ray cast to the right; a point on a crossed edge answers the box test.
   function automatic bit point_in_poly(longint px, longint py);
      int j, hits;
      hits = 0;
      if (shadow_count < pip_pkg::MinPolyVerts) return 0;
      for (int i = 0; i < shadow_count; i++) begin
         j = (i + 1 == shadow_count) ? 0 : i + 1;
         if (segs_meet(shadow_x[i], shadow_y[i], shadow_x[j], shadow_y[j],
                       px, py, RayEndX, py)) begin
            if (turn_of(shadow_x[i], shadow_y[i], px, py, shadow_x[j], shadow_y[j]) == 0)
               return in_box(shadow_x[i], shadow_y[i], px, py, shadow_x[j], shadow_y[j]);
            hits++;
         end
      end
      return hits[0];
   endfunction

   // Doubled shoelace area, absolute and saturated to 33 bits.
   function automatic logic [32:0] doubled_area();
      longint sum;
      int j;
      sum = 0;
      for (int i = 0; i < shadow_count; i++) begin
         j = (i + 1 == shadow_count) ? 0 : i + 1;
         sum += longint'(shadow_x[i]) * shadow_y[j] - longint'(shadow_y[i]) * shadow_x[j];
      end
      if (sum < 0) sum = -sum;
      if (sum > AreaCap) sum = AreaCap;
      return sum[32:0];
   endfunction

   // Update the shadow polygon for one accepted beat and return its result.
   function automatic poly_result apply_beat(pip_pkg::action_type act, int x, int y);
      poly_result r;
      r = '0;
      case (act)
         pip_pkg::ACT_CLEAR: shadow_count = 0;
         pip_pkg::ACT_APPEND: begin
            if (shadow_count < pip_pkg::MaxVertices) begin
               shadow_x[shadow_count] = x;
               shadow_y[shadow_count] = y;
               shadow_count++;
            end else begin
               r.drop = 1'b1;
            end
         end
         pip_pkg::ACT_POINT: r.in_poly = point_in_poly(x, y);
         default: r.area = doubled_area();
      endcase
      r.count = shadow_count[6:0];
      return r;
   endfunction

   // Send one beat, honoring bursts and gaps, and log its expected result.
   task automatic send_beat(pip_pkg::action_type act, int x, int y, bit typed = 0,
                            poly_result typed_res = '0);
      poly_result r;
      int gap;
      int xs, ys;
      // The block sees only the low 16 bits of each coordinate, as signed values.
      xs = {{16{x[15]}}, x[15:0]};
      ys = {{16{y[15]}}, y[15:0]};
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {y[15:0], x[15:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_beat(act, xs, ys);
      pending_results.push_back(typed ? typed_res : r);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver stall pattern: phases of always ready, random and periodic.
   always @(posedge clock) begin
      case ((cycle_count / 500) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (cycle_count % 7) < 4;
      endcase
   end

   // Result checker.
   always @(posedge clock) begin
      poly_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.in_poly) begin
               $display("%0t: inside expected %0d actual %0d", $time, want.in_poly,
                        rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[33:1] !== want.area) begin
               $display("%0t: twice_area expected %0d actual %0d", $time, want.area,
                        rsp_tdata[33:1]);
               error_count++;
            end
            if (rsp_tdata[40:34] !== want.count) begin
               $display("%0t: vertex_count expected %0d actual %0d", $time, want.count,
                        rsp_tdata[40:34]);
               error_count++;
            end
            if (rsp_tdata[41] !== want.drop) begin
               $display("%0t: dropped expected %0d actual %0d", $time, want.drop,
                        rsp_tdata[41]);
               error_count++;
            end
         end
      end
   end

   function automatic poly_result res_of(bit in_flag, longint area, int count, bit drop);
      poly_result r;
      r.in_poly = in_flag;
      r.area = area[32:0];
      r.count = count[6:0];
      r.drop = drop;
      return r;
   endfunction

   // Stimulus.
   initial begin
      stim_row rows[$];
      int n, q, lim, k, vx, vy;
      bit tiny;
      pip_pkg::action_type act;

      // Directed rows: empty store, full-scale square, on-edge points, overflow.
      rows = '{
         '{pip_pkg::ACT_AREA,   0, 0, 1, res_of(0, 0, 0, 0)},
         '{pip_pkg::ACT_POINT,  0, 0, 1, res_of(0, 0, 0, 0)},
         '{pip_pkg::ACT_APPEND, -32768, -32768, 1, res_of(0, 0, 1, 0)},
         '{pip_pkg::ACT_AREA,   0, 0, 1, res_of(0, 0, 1, 0)},
         '{pip_pkg::ACT_APPEND, 32767, -32768, 1, res_of(0, 0, 2, 0)},
         '{pip_pkg::ACT_POINT,  0, -32768, 1, res_of(0, 0, 2, 0)},
         '{pip_pkg::ACT_APPEND, 32767, 32767, 1, res_of(0, 0, 3, 0)},
         '{pip_pkg::ACT_APPEND, -32768, 32767, 1, res_of(0, 0, 4, 0)},
         '{pip_pkg::ACT_AREA,   0, 0, 1, res_of(0, 64'd8589672450, 4, 0)},
         '{pip_pkg::ACT_POINT,  0, 0, 1, res_of(1, 0, 4, 0)},
         '{pip_pkg::ACT_POINT,  32767, 0, 1, res_of(1, 0, 4, 0)},
         '{pip_pkg::ACT_POINT,  -32768, 0, 1, res_of(1, 0, 4, 0)},
         '{pip_pkg::ACT_POINT,  0, 32767, 1, res_of(1, 0, 4, 0)},
         '{pip_pkg::ACT_POINT,  -32768, -32768, 0, '0},
         // Going round the square a second time overflows the area.
         '{pip_pkg::ACT_APPEND, -32768, -32768, 0, '0},
         '{pip_pkg::ACT_APPEND, 32767, -32768, 0, '0},
         '{pip_pkg::ACT_APPEND, 32767, 32767, 0, '0},
         '{pip_pkg::ACT_APPEND, -32768, 32767, 1, res_of(0, 0, 8, 0)},
         '{pip_pkg::ACT_AREA,   0, 0, 1, res_of(0, AreaCap, 8, 0)},
         '{pip_pkg::ACT_POINT,  100, -5, 0, '0},
         '{pip_pkg::ACT_CLEAR,  -1, -1, 1, res_of(0, 0, 0, 0)},
         '{pip_pkg::ACT_POINT,  5, 5, 1, res_of(0, 0, 0, 0)}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_beat(rows[i].act, rows[i].x, rows[i].y, rows[i].typed,
                                  rows[i].res);
      wait_drained();

      // Random polygons followed by area queries, random points and points aimed at vertices and edges.
      while (sent_count < 1000) begin
         if (sent_count > 500 && sent_count < 520) wait_drained();
         tiny = $urandom_range(0, 1);
         lim = tiny ? 8 : 32767;
         send_beat(pip_pkg::ACT_CLEAR, $urandom, $urandom);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 9);
         for (int i = 0; i < n; i++)
            send_beat(pip_pkg::ACT_APPEND, $urandom_range(0, 2 * lim) - lim,
                      $urandom_range(0, 2 * lim) - lim);
         q = $urandom_range(2, 10);
         for (int i = 0; i < q; i++) begin
            k = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
            case ($urandom_range(0, 5))
               0: send_beat(pip_pkg::ACT_AREA, $urandom, $urandom);
               1: begin
                  // Midpoint of an edge, or the origin when the store is empty.
                  vx = (shadow_x[k] + shadow_x[(k + 1) % (shadow_count + (shadow_count == 0))]) / 2;
                  vy = (shadow_y[k] + shadow_y[(k + 1) % (shadow_count + (shadow_count == 0))]) / 2;
                  send_beat(pip_pkg::ACT_POINT, shadow_count ? vx : 0, shadow_count ? vy : 0);
               end
               2: send_beat(pip_pkg::ACT_POINT, $urandom_range(0, 2 * lim) - lim,
                            shadow_count ? shadow_y[k] : 0);
               3: send_beat(pip_pkg::ACT_POINT, $urandom, $urandom);
               4: begin
                  // Noise: any action with any coordinates.
                  act = pip_pkg::action_type'($urandom_range(0, 3));
                  send_beat(act, $urandom, $urandom);
               end
               default: send_beat(pip_pkg::ACT_POINT, $urandom_range(0, 2 * lim) - lim,
                                  $urandom_range(0, 2 * lim) - lim);
            endcase
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

@@ point_in_polygon_ray_cast.f @@
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_ram.sv
rtl/pip_datapath.sv
rtl/pip_ctrl.sv
rtl/point_in_polygon_ray_cast.sv
tb/tb_top.sv
